// ===== design/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_POP_FRONT  = 3'd1;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_SHOW       = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT_RIGHTWARD,
        CMD_SHIFT_LEFTWARD,
        CMD_PUT_REAR,
        CMD_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] item;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/deq_in_if.sv =====
`default_nettype none

interface deq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink (input valid, input opcode, input item_value, output ready);
endinterface

`default_nettype wire

// ===== design/deq_out_if.sv =====
`default_nettype none

interface deq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last_of_run;

    modport source (output valid, output status, output out_value, output last_of_run,
                    input ready);
    modport sink (input valid, input status, input out_value, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== design/deq_cell.sv =====
`default_nettype none

module deq_cell (
    input  wire logic                      clk,
    input  wire logic [deq_pkg::IDX_W-1:0] idx,
    input  wire deq_pkg::cell_ctrl_t       ctrl,
    input  wire logic signed [31:0]        left_data,
    input  wire logic signed [31:0]        right_data,
    input  wire logic signed [31:0]        head_data,
    output logic signed [31:0]             data,
    output logic signed [31:0]             rear_data
);
    import deq_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   rear_pos;

    assign idx_ext  = CNT_W'(idx);
    assign rear_pos = ctrl.count - CNT_W'(1);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CMD_SHIFT_RIGHTWARD: data_next = left_data;
            CMD_SHIFT_LEFTWARD:  data_next = right_data;
            CMD_PUT_REAR:
            begin
                if (idx_ext == ctrl.count)
                    data_next = ctrl.item;
            end
            CMD_ROTATE:
            begin
                if (idx_ext == rear_pos)
                    data_next = head_data;
                else if (idx_ext < rear_pos)
                    data_next = right_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign rear_data = (idx_ext == rear_pos) ? data_reg : 32'sd0;

endmodule

`default_nettype wire

// ===== design/double_ended_queue.sv =====
`default_nettype none

// A bounded double-ended queue of QUEUE_DEPTH signed 32-bit items, held in a row of cells
// ordered from front to rear. Every accepted item gives its results through an output
// register: a push or pop gives one result, and the next item is taken once that result
// is drained or the output register is free. Show gives one result per held item, one per
// cycle while the output is drained, by rotating the row of cells one step per result, so
// it occupies the block until every held item has been given; input is not taken
// meanwhile. Pushing into a full queue reports full and drops the item, popping or showing
// an empty queue reports empty, and unused opcodes are dropped with no result.
module double_ended_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp
);
    import deq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   shown_reg, shown_next;
    logic               valid_reg, valid_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] value_reg, value_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    cell_cmd_t          cmd;
    logic signed [31:0] cell_data [QUEUE_DEPTH];
    logic signed [31:0] cell_rear [QUEUE_DEPTH];
    logic signed [31:0] rear_value;
    logic               out_free;
    logic               accept;
    logic               full;
    logic               empty;

    assign out_free  = !valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.cmd   = cmd;
    assign ctrl.count = count_reg;
    assign ctrl.item  = req.item_value;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_in;
        logic signed [31:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = req.item_value;
        end
        else
        begin : g_inner_left
            assign left_in = cell_data[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_final
            assign right_in = 32'sd0;
        end
        else
        begin : g_inner_right
            assign right_in = cell_data[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (cell_data[0]),
            .data       (cell_data[i]),
            .rear_data  (cell_rear[i])
        );
    end

    always_comb
    begin
        rear_value = 32'sd0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            rear_value = rear_value | cell_rear[i];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        shown_next  = shown_reg;
        valid_next  = valid_reg && !rsp.ready;
        status_next = status_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        cmd         = CMD_HOLD;

        if (state_reg == ST_SHOW)
        begin
            if (out_free)
            begin
                cmd         = CMD_ROTATE;
                valid_next  = 1'b1;
                status_next = STATUS_DONE;
                value_next  = cell_data[0];
                last_next   = (shown_reg == count_reg - CNT_W'(1));
                shown_next  = shown_reg + CNT_W'(1);
                if (last_next)
                    state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            value_next  = 32'sd0;
            last_next   = 1'b1;
            status_next = STATUS_DONE;
            unique case (req.opcode) inside
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    valid_next = 1'b1;
                    if (full)
                        status_next = STATUS_FULL;
                    else
                    begin
                        cmd = (req.opcode == OP_PUSH_FRONT) ? CMD_SHIFT_RIGHTWARD
                                                            : CMD_PUT_REAR;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR:
                begin
                    valid_next = 1'b1;
                    if (empty)
                        status_next = STATUS_EMPTY;
                    else
                    begin
                        if (req.opcode == OP_POP_FRONT)
                        begin
                            cmd        = CMD_SHIFT_LEFTWARD;
                            value_next = cell_data[0];
                        end
                        else
                            value_next = rear_value;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_SHOW:
                begin
                    valid_next = 1'b1;
                    if (empty)
                        status_next = STATUS_EMPTY;
                    else
                    begin
                        cmd        = CMD_ROTATE;
                        value_next = cell_data[0];
                        last_next  = (count_reg == CNT_W'(1));
                        shown_next = CNT_W'(1);
                        if (!last_next)
                            state_next = ST_SHOW;
                    end
                end
                default:
                begin
                    valid_next = valid_reg && !rsp.ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            shown_reg  <= '0;
            valid_reg  <= 1'b0;
            status_reg <= STATUS_DONE;
            value_reg  <= 32'sd0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            shown_reg  <= shown_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
            value_reg  <= value_next;
            last_reg   <= last_next;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_value   = value_reg;
    assign rsp.last_of_run = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("held count exceeds the queue depth");

    a_no_input_during_show: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHOW |-> !req.ready)
        else $error("input taken while a show is running");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full && (req.opcode == OP_PUSH_FRONT || req.opcode == OP_PUSH_REAR)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not add an item");

    a_show_not_beyond: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHOW |-> shown_reg < count_reg)
        else $error("show ran past the rear item");

endmodule

`default_nettype wire

// ===== tb/deq_result_monitor.sv =====
// Watches both channels, keeps its own copy of the queue and compares every result.
module deq_result_monitor (
    input  wire logic clk,
    input  wire logic rst_n,
    deq_in_if         req,
    deq_out_if        rsp,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic               last;
    } deq_result_t;

    deq_result_t        awaited_results[$];
    logic signed [31:0] ring [QUEUE_DEPTH];
    int                 head;
    int                 fill;

    function automatic void queue_result(logic [1:0] status, logic signed [31:0] value,
                                         logic last);
        deq_result_t r;
        r.status = status;
        r.value  = value;
        r.last   = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void apply_item(logic [2:0] op, logic signed [31:0] value);
        int pos;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (fill >= QUEUE_DEPTH)
                begin
                    queue_result(STATUS_FULL, 0, 1'b1);
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        pos  = head;
                    end
                    else
                    begin
                        pos = (head + fill) % QUEUE_DEPTH;
                    end
                    ring[pos] = value;
                    fill++;
                    queue_result(STATUS_DONE, 0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (fill == 0)
                begin
                    queue_result(STATUS_EMPTY, 0, 1'b1);
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        pos  = head;
                        head = (head + 1) % QUEUE_DEPTH;
                    end
                    else
                    begin
                        pos = (head + fill - 1) % QUEUE_DEPTH;
                    end
                    fill--;
                    queue_result(STATUS_DONE, ring[pos], 1'b1);
                end
            end
            OP_SHOW:
            begin
                if (fill == 0)
                begin
                    queue_result(STATUS_EMPTY, 0, 1'b1);
                end
                else
                begin
                    for (int k = 0; k < fill; k++)
                    begin
                        queue_result(STATUS_DONE, ring[(head + k) % QUEUE_DEPTH], k == fill - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, logic signed [31:0] want,
                                          logic signed [31:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deq_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            head       = 0;
            fill       = 0;
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    note_mismatch("result with nothing awaited, out_value", 0, rsp.out_value);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        note_mismatch("status", want.status, rsp.status);
                    end
                    if (rsp.out_value !== want.value)
                    begin
                        note_mismatch("out_value", want.value, rsp.out_value);
                    end
                    if (rsp.last_of_run !== want.last)
                    begin
                        note_mismatch("last_of_run", want.last, rsp.last_of_run);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                apply_item(req.opcode, req.item_value);
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/double_ended_queue_test.sv =====
module double_ended_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    localparam int         IDLE_LIMIT     = 5000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         ITEMS_PER_MIX  = 125;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;

    typedef enum int {FILL_BIAS, DRAIN_BIAS, EVEN_MIX} op_mix_t;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 27;
    int   recv_idle_pct = 56;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    int   mismatches;
    int   pending;

    deq_in_if  req_ch ();
    deq_out_if rsp_ch ();

    double_ended_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deq_result_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic offer(input logic [2:0] op, input logic signed [31:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.item_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_opcode(op_mix_t mix);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        push_pct = (mix == FILL_BIAS) ? 75 : (mix == DRAIN_BIAS) ? 20 : 50;
        if (r < 3)
        begin
            return OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
        end
        if (r < 11)
        begin
            return OP_SHOW;
        end
        if ($urandom_range(0, 99) < push_pct)
        begin
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
    endfunction

    // A long hold-off is counted down here while the sender keeps offering items.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        op_mix_t mix;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_PUSH_FRONT;
        req_ch.item_value <= 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        offer(OP_POP_FRONT, 0);
        offer(OP_POP_REAR, -1);
        offer(OP_SHOW, 0);
        offer(OP_PUSH_FRONT, 32'sh8000_0000);
        offer(OP_PUSH_REAR, 32'sh7fff_ffff);
        offer(OP_SHOW, 0);
        offer(OP_POP_REAR, 0);
        offer(OP_POP_FRONT, 0);
        for (int k = 0; k < 3; k++)
        begin
            offer(OP_UNUSED_FIRST + 3'(k), $urandom());
        end
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            offer((k % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
        end
        offer(OP_PUSH_REAR, -1);
        offer(OP_PUSH_FRONT, 1);
        offer(OP_SHOW, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 27 : 0;
            if (phase == 2)
            begin
                hold_left = HOLD_CYCLES;
            end
            for (int n = 0; n < ITEMS_PER_MIX; n++)
            begin
                if (n % 20 == 0)
                begin
                    mix = op_mix_t'($urandom_range(0, 2));
                end
                offer(pick_opcode(mix), pick_value());
            end
        end
        req_ch.valid <= 1'b0;

        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
